// ===== sv/phc_pkg.sv =====
// Shared types, widths and constants of the pad hit clusterizer.
package phc_pkg;

   localparam int HIT_W   = 16;
   localparam int TIME_W  = 40;
   localparam int LAYER_W = 4;
   localparam int SECT_W  = 2;
   localparam int ROW_W   = 8;
   localparam int COL_W   = 8;
   localparam int TRIG_W  = 2;
   localparam int CLUS_W  = 16;
   localparam int BIN_W   = 40;

   // bin = floor((t + 1) * 16 / 1000) = floor(2 * (t + 1) / 125)
   localparam int SUM_W      = TIME_W + 1;
   localparam int DIVIDEND_W = SUM_W + 1;
   localparam int CHUNK_W    = 7;
   localparam int REM_W      = 7;
   localparam int DIV_STEPS  = DIVIDEND_W / CHUNK_W;
   localparam logic [REM_W:0] DIVISOR = (REM_W + 1)'(125);

   localparam logic [TRIG_W-1:0] TRIG_DOUBLE = TRIG_W'(2);

   typedef struct packed {
      logic               slice_start;
      logic [HIT_W-1:0]   hit_index;
      logic [LAYER_W-1:0] layer;
      logic [SECT_W-1:0]  sector;
      logic [ROW_W-1:0]   pad_row;
      logic [COL_W-1:0]   pad_column;
      logic [TRIG_W-1:0]  trigger_type;
   } hit_type;

   typedef struct packed {
      hit_type            hit;
      logic [BIN_W-1:0]   time_bin;
   } item_type;

   typedef struct packed {
      logic [CLUS_W-1:0]  cluster_index;
      logic [HIT_W-1:0]   member_index;
      logic               opens_cluster;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [REM_W-1:0]   rem;
      logic [CHUNK_W-1:0] quo;
   } div_step_type;

   // restoring division of one chunk of dividend bits by the divisor
   function automatic div_step_type div_step(input logic [REM_W-1:0] rem_i,
                                             input logic [CHUNK_W-1:0] bits_i);
      logic [REM_W:0]     acc;
      logic [REM_W-1:0]   r;
      logic [CHUNK_W-1:0] q;
      div_step_type       res;
      r = rem_i;
      q = '0;
      for (int i = CHUNK_W - 1; i >= 0; i--) begin
         acc = {r, bits_i[i]};
         if (acc >= DIVISOR) begin
            acc  = acc - DIVISOR;
            q[i] = 1'b1;
         end
         r = acc[REM_W-1:0];
      end
      res.rem = r;
      res.quo = q;
      return res;
   endfunction

endpackage

// ===== sv/phc_req_if.sv =====
// Hit channel into the clusterizer.
interface phc_req_if;
   logic                         valid;
   logic                         ready;
   logic                         slice_start;
   logic [phc_pkg::HIT_W-1:0]    hit_index;
   logic [phc_pkg::TIME_W-1:0]   time_ns;
   logic [phc_pkg::LAYER_W-1:0]  layer;
   logic [phc_pkg::SECT_W-1:0]   sector;
   logic [phc_pkg::ROW_W-1:0]    pad_row;
   logic [phc_pkg::COL_W-1:0]    pad_column;
   logic [phc_pkg::TRIG_W-1:0]   trigger_type;

   modport source (output valid, slice_start, hit_index, time_ns, layer, sector,
                   pad_row, pad_column, trigger_type, input ready);
   modport sink (input valid, slice_start, hit_index, time_ns, layer, sector,
                 pad_row, pad_column, trigger_type, output ready);
endinterface

// ===== sv/phc_rsp_if.sv =====
// Cluster assignment channel out of the clusterizer.
interface phc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [phc_pkg::CLUS_W-1:0]   cluster_index;
   logic [phc_pkg::HIT_W-1:0]    member_index;
   logic                         opens_cluster;
   logic                         last_of_run;

   modport source (output valid, cluster_index, member_index, opens_cluster,
                   last_of_run, input ready);
   modport sink (input valid, cluster_index, member_index, opens_cluster,
                 last_of_run, output ready);
endinterface

// ===== sv/phc_front.sv =====
// Front end: accepts hits and computes the time bin in a pipelined divider.
module phc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  phc_pkg::hit_type           in_hit,
   input  logic [phc_pkg::TIME_W-1:0] in_time,
   output logic                       out_valid,
   input  logic                       out_ready,
   output phc_pkg::item_type          out_item
);

   localparam int STAGES = phc_pkg::DIV_STEPS + 1;

   logic [STAGES-1:0]                 valid_ff;
   phc_pkg::hit_type                  hit_ff [STAGES];
   logic [phc_pkg::DIVIDEND_W-1:0]    quo_ff [STAGES];
   logic [phc_pkg::REM_W-1:0]         rem_ff [STAGES];
   logic [STAGES:0]                   load_ok;

   assign load_ok[STAGES] = out_ready;

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic                           valid_in;
      phc_pkg::hit_type               hit_in;
      logic [phc_pkg::DIVIDEND_W-1:0] quo_in;
      logic [phc_pkg::REM_W-1:0]      rem_in;

      assign load_ok[s] = !valid_ff[s] || load_ok[s+1];

      if (s == 0) begin : g_head
         assign valid_in = in_valid;
         assign hit_in   = in_hit;
         assign quo_in   = {phc_pkg::SUM_W'(in_time) + phc_pkg::SUM_W'(1), 1'b0};
         assign rem_in   = '0;
      end else begin : g_step
         localparam int MSB = phc_pkg::DIVIDEND_W - 1 - phc_pkg::CHUNK_W * (s - 1);
         phc_pkg::div_step_type step;

         assign step     = phc_pkg::div_step(rem_ff[s-1],
                                             quo_ff[s-1][MSB -: phc_pkg::CHUNK_W]);
         assign valid_in = valid_ff[s-1];
         assign hit_in   = hit_ff[s-1];
         assign rem_in   = step.rem;
         always_comb begin
            quo_in = quo_ff[s-1];
            quo_in[MSB -: phc_pkg::CHUNK_W] = step.quo;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (load_ok[s]) begin
            valid_ff[s] <= valid_in;
         end
         if (load_ok[s]) begin
            hit_ff[s] <= hit_in;
            quo_ff[s] <= quo_in;
            rem_ff[s] <= rem_in;
         end
      end
   end

   assign in_ready          = load_ok[0];
   assign out_valid         = valid_ff[STAGES-1];
   assign out_item.hit      = hit_ff[STAGES-1];
   assign out_item.time_bin = quo_ff[STAGES-1][phc_pkg::BIN_W-1:0];

endmodule

// ===== sv/phc_queue.sv =====
// Short queue between front end and cluster logic.
module phc_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  phc_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output phc_pkg::item_type out_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   phc_pkg::item_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ===== sv/phc_back.sv =====
// Back end: cluster decision, split handling and output register.
module phc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  phc_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output phc_pkg::rsp_type  out_rsp
);

   logic [phc_pkg::BIN_W-1:0]   prev_bin_ff, prev_bin_in;
   logic [phc_pkg::LAYER_W-1:0] prev_layer_ff, prev_layer_in;
   logic [phc_pkg::SECT_W-1:0]  prev_sector_ff, prev_sector_in;
   logic [phc_pkg::ROW_W-1:0]   prev_row_ff, prev_row_in;
   logic [phc_pkg::COL_W-1:0]   prev_column_ff, prev_column_in;
   logic [phc_pkg::HIT_W-1:0]   prev_hit_ff, prev_hit_in;
   logic [phc_pkg::TRIG_W-1:0]  last_trig_ff, last_trig_in;
   logic [phc_pkg::CLUS_W-1:0]  count_ff, count_in;
   logic                        open_ff, open_in;
   logic                        pend_valid_ff, pend_valid_in;
   phc_pkg::rsp_type            pend_ff, pend_in;
   logic                        out_valid_ff, out_valid_in;
   phc_pkg::rsp_type            out_ff, out_in;

   phc_pkg::hit_type            hit;
   logic                        can_load, take;
   logic                        hard_break, fresh, split;
   logic [phc_pkg::CLUS_W-1:0]  base, idx;
   phc_pkg::rsp_type            first_rsp, second_rsp;

   assign hit      = in_item.hit;
   assign can_load = !out_valid_ff || out_ready;
   assign in_ready = can_load && !pend_valid_ff;
   assign take     = in_valid && in_ready;

   always_comb begin
      hard_break = (in_item.time_bin != prev_bin_ff)
                || (hit.layer != prev_layer_ff)
                || (hit.sector != prev_sector_ff)
                || (hit.pad_row != prev_row_ff)
                || ({1'b0, hit.pad_column} >
                    {1'b0, prev_column_ff} + (phc_pkg::COL_W + 1)'(1))
                || (hit.trigger_type == phc_pkg::TRIG_DOUBLE
                    && last_trig_ff == phc_pkg::TRIG_DOUBLE);
      split = !hit.slice_start && open_ff && !hard_break
           && hit.trigger_type[0] && last_trig_ff[0];
      fresh = hit.slice_start || !open_ff || hard_break || split;
      base  = hit.slice_start ? '0 : count_ff;
      idx   = fresh ? base : count_ff - phc_pkg::CLUS_W'(1);

      first_rsp.cluster_index  = idx;
      first_rsp.member_index   = split ? prev_hit_ff : hit.hit_index;
      first_rsp.opens_cluster  = fresh;
      first_rsp.last_of_run    = !split;
      second_rsp.cluster_index = idx;
      second_rsp.member_index  = hit.hit_index;
      second_rsp.opens_cluster = 1'b0;
      second_rsp.last_of_run   = 1'b1;
   end

   always_comb begin
      prev_bin_in    = prev_bin_ff;
      prev_layer_in  = prev_layer_ff;
      prev_sector_in = prev_sector_ff;
      prev_row_in    = prev_row_ff;
      prev_column_in = prev_column_ff;
      prev_hit_in    = prev_hit_ff;
      last_trig_in   = last_trig_ff;
      count_in       = count_ff;
      open_in        = open_ff;
      pend_valid_in  = pend_valid_ff;
      pend_in        = pend_ff;
      out_valid_in   = out_valid_ff;
      out_in         = out_ff;

      if (can_load) begin
         out_valid_in = pend_valid_ff || in_valid;
         out_in       = pend_valid_ff ? pend_ff : first_rsp;
         if (pend_valid_ff) begin
            pend_valid_in = 1'b0;
         end
      end

      if (take) begin
         prev_bin_in    = in_item.time_bin;
         prev_layer_in  = hit.layer;
         prev_sector_in = hit.sector;
         prev_row_in    = hit.pad_row;
         prev_column_in = hit.pad_column;
         prev_hit_in    = hit.hit_index;
         last_trig_in   = hit.trigger_type;
         open_in        = 1'b1;
         if (fresh) begin
            count_in = base + phc_pkg::CLUS_W'(1);
         end
         pend_valid_in = split;
         pend_in       = second_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_bin_ff    <= '0;
         prev_layer_ff  <= '0;
         prev_sector_ff <= '0;
         prev_row_ff    <= '0;
         prev_column_ff <= '0;
         prev_hit_ff    <= '0;
         last_trig_ff   <= '0;
         count_ff       <= '0;
         open_ff        <= 1'b0;
         pend_valid_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         prev_bin_ff    <= prev_bin_in;
         prev_layer_ff  <= prev_layer_in;
         prev_sector_ff <= prev_sector_in;
         prev_row_ff    <= prev_row_in;
         prev_column_ff <= prev_column_in;
         prev_hit_ff    <= prev_hit_in;
         last_trig_ff   <= last_trig_in;
         count_ff       <= count_in;
         open_ff        <= open_in;
         pend_valid_ff  <= pend_valid_in;
         out_valid_ff   <= out_valid_in;
      end
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_rsp   = out_ff;

endmodule

// ===== sv/pad_hit_clusterizer.sv =====
// Pad hit clusterizer top level: front end, queue and cluster logic.
// Takes one hit per cycle when not held off by back-pressure from the result
// side, and gives each hit a cluster number within its slice. A hit that splits
// a cluster (two odd trigger types in a row) yields two beats (the previous hit,
// then this hit) and holds off the next hit until the second beat is loaded;
// every other hit yields one beat. The time bin floor((t+1)*16/1000) is formed
// by a six-stage restoring divider by 125, seven quotient bits per stage. A
// queue of QUEUE_DEPTH hits lets the front end keep taking hits while the
// result side is stalled.
module pad_hit_clusterizer #(
   parameter int QUEUE_DEPTH = 4
) (
   input logic        clock,
   input logic        reset,
   phc_req_if.sink    req_bus,
   phc_rsp_if.source  rsp_bus
);

   phc_pkg::hit_type  req_hit;
   logic              f2q_valid, f2q_ready;
   phc_pkg::item_type f2q_item;
   logic              q2b_valid, q2b_ready;
   phc_pkg::item_type q2b_item;
   phc_pkg::rsp_type  rsp;

   assign req_hit.slice_start  = req_bus.slice_start;
   assign req_hit.hit_index    = req_bus.hit_index;
   assign req_hit.layer        = req_bus.layer;
   assign req_hit.sector       = req_bus.sector;
   assign req_hit.pad_row      = req_bus.pad_row;
   assign req_hit.pad_column   = req_bus.pad_column;
   assign req_hit.trigger_type = req_bus.trigger_type;

   phc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_hit    (req_hit),
      .in_time   (req_bus.time_ns),
      .out_valid (f2q_valid),
      .out_ready (f2q_ready),
      .out_item  (f2q_item)
   );

   phc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f2q_valid),
      .in_ready  (f2q_ready),
      .in_item   (f2q_item),
      .out_valid (q2b_valid),
      .out_ready (q2b_ready),
      .out_item  (q2b_item)
   );

   phc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q2b_valid),
      .in_ready  (q2b_ready),
      .in_item   (q2b_item),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_rsp   (rsp)
   );

   assign rsp_bus.cluster_index = rsp.cluster_index;
   assign rsp_bus.member_index  = rsp.member_index;
   assign rsp_bus.opens_cluster = rsp.opens_cluster;
   assign rsp_bus.last_of_run   = rsp.last_of_run;

`ifndef ASSERT_OFF
   // only the first beat of a split is not last, and it always opens
   a_split_opens : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.last_of_run |-> rsp_bus.opens_cluster)
      else $error("split beat does not open a cluster");

   // second beat of a split follows at once, same cluster, not opening
   a_split_pair : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.last_of_run |=>
         rsp_bus.valid && rsp_bus.last_of_run && !rsp_bus.opens_cluster
         && rsp_bus.cluster_index == $past(rsp_bus.cluster_index))
      else $error("split beat pair broken");

   // cluster logic takes a hit only when the result register can load
   a_back_load : assert property (@(posedge clock) disable iff (reset)
      q2b_valid && q2b_ready |-> !rsp_bus.valid || rsp_bus.ready)
      else $error("hit taken while result register is blocked");
`endif

endmodule
